>>> rtl/ckb_pkg.sv
// Shared types and constants of the color-key, tint and alpha-blend compositor.
package ckb_pkg;

  localparam int unsigned PixW   = 24;
  localparam int unsigned ChanW  = 8;
  localparam int unsigned NChan  = 3;
  localparam int unsigned CfgIdxW = 3;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] REG_KEY_COLOR     = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_KEY_TOLERANCE = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_GAIN          = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_OPACITY       = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_EFFECT_MODE   = 3'd4;

  // Effect selector codes; the unused code behaves as no effect
  localparam logic [1:0] EFF_NONE   = 2'd0;
  localparam logic [1:0] EFF_INVERT = 2'd1;
  localparam logic [1:0] EFF_GRAY   = 2'd2;

  localparam logic [6:0]  OPACITY_MAX = 7'd100;
  localparam logic [15:0] GAIN_UNITY  = 16'd256;

  // Gray weights in Q16, summing to 65536
  localparam logic [15:0] GRAY_W0 = 16'd19595;
  localparam logic [15:0] GRAY_W1 = 16'd38470;
  localparam logic [15:0] GRAY_W2 = 16'd7471;

  // Divide by 100: (v * 41944) >> 22 is exact for v <= 25500
  localparam logic [15:0] RECIP_100 = 16'd41944;
  localparam int unsigned RECIP_SHIFT = 22;

  typedef enum logic [1:0] {
    CLS_KEY    = 2'd0,
    CLS_INVERT = 2'd1,
    CLS_BLEND  = 2'd2
  } ckb_cls_e;

  typedef struct packed {
    logic [PixW-1:0] key_color;
    logic [8:0]      key_tolerance;  // two's complement
    logic [15:0]     gain;
    logic [6:0]      opacity;
    logic [1:0]      effect_mode;
  } ckb_cfg_t;

  typedef struct packed {
    ckb_cls_e        cls;
    logic [PixW-1:0] sprite;
    logic [PixW-1:0] backdrop;
  } ckb_req_t;

endpackage

>>> rtl/ckb_front.sv
// Front end: accepts requests, runs the key test and classifies each pixel pair.
module ckb_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  ckb_pkg::ckb_cfg_t cfg_i,
  input  logic              start_i,
  input  logic [23:0]       sprite_pixel_i,
  input  logic [23:0]       backdrop_pixel_i,
  output logic              busy_o,
  output logic              req_valid_o,
  output ckb_pkg::ckb_req_t req_o,
  input  logic              req_taken_i
);
  import ckb_pkg::*;

  logic              valid_q, valid_d;
  ckb_req_t          req_q;
  logic              accept;
  logic [NChan-1:0]  chan_match;
  logic              keyed;
  ckb_cls_e          cls;

  always_comb begin
    for (int i = 0; i < NChan; i++) begin
      logic [ChanW-1:0] s, k, delta;
      s     = sprite_pixel_i[i*ChanW +: ChanW];
      k     = cfg_i.key_color[i*ChanW +: ChanW];
      delta = (s >= k) ? (s - k) : (k - s);
      // negative tolerance never matches
      chan_match[i] = !cfg_i.key_tolerance[8] && (delta <= cfg_i.key_tolerance[7:0]);
    end
  end

  assign keyed = &chan_match;

  always_comb begin
    priority if (keyed) begin
      cls = CLS_KEY;
    end else if (cfg_i.effect_mode == EFF_INVERT) begin
      cls = CLS_INVERT;
    end else begin
      cls = CLS_BLEND;
    end
  end

  assign busy_o      = valid_q && !req_taken_i;
  assign accept      = start_i && !busy_o;
  assign req_valid_o = valid_q;
  assign req_o       = req_q;

  always_comb begin
    valid_d = valid_q;
    if (req_taken_i) valid_d = 1'b0;
    if (accept)      valid_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_q.cls      <= cls;
      req_q.sprite   <= sprite_pixel_i;
      req_q.backdrop <= backdrop_pixel_i;
    end
  end

endmodule

>>> rtl/ckb_queue.sv
// Two-entry request queue between the front end and the datapath.
module ckb_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_valid_i,
  input  ckb_pkg::ckb_req_t push_req_i,
  output logic              push_taken_o,
  output logic              pop_valid_o,
  output ckb_pkg::ckb_req_t pop_req_o,
  input  logic              pop_ready_i
);
  import ckb_pkg::*;

  localparam int unsigned Depth = 2;
  localparam int unsigned PtrW  = $clog2(Depth);

  ckb_req_t           mem_q [Depth];
  logic [PtrW-1:0]    wptr_q, wptr_d, rptr_q, rptr_d;
  logic [PtrW:0]      count_q, count_d;
  logic               full, empty, push, pop;

  assign full  = (count_q == (PtrW+1)'(Depth));
  assign empty = (count_q == '0);
  assign pop   = !empty && pop_ready_i;
  assign push  = push_valid_i && (!full || pop);

  assign push_taken_o = push;
  assign pop_valid_o  = !empty;
  assign pop_req_o    = mem_q[rptr_q];

  always_comb begin
    wptr_d  = push ? wptr_q + 1'b1 : wptr_q;
    rptr_d  = pop  ? rptr_q + 1'b1 : rptr_q;
    count_d = count_q + (PtrW+1)'(push) - (PtrW+1)'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      wptr_q  <= wptr_d;
      rptr_q  <= rptr_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wptr_q] <= push_req_i;
  end

endmodule

>>> rtl/ckb_back.sv
// Datapath: gain, grayscale, percent blend and output register, one pixel per clock.
module ckb_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  ckb_pkg::ckb_cfg_t cfg_i,
  input  logic              req_valid_i,
  input  ckb_pkg::ckb_req_t req_i,
  output logic              req_ready_o,
  output logic              out_valid_o,
  output logic [23:0]       out_pixel_o
);
  import ckb_pkg::*;

  assign req_ready_o = 1'b1;

  // stage 1: gain products
  logic              v1_q;
  ckb_req_t          r1_q;
  logic [23:0]       gp1_q [NChan];
  // stage 2: saturated channels and gray products
  logic              v2_q;
  ckb_req_t          r2_q;
  logic [ChanW-1:0]  c2_q [NChan];
  logic [23:0]       wp2_q [NChan];
  // stage 3: blend sums
  logic              v3_q;
  ckb_req_t          r3_q;
  logic [14:0]       sum3_q [NChan];
  // stage 4: reciprocal products
  logic              v4_q;
  ckb_req_t          r4_q;
  logic [30:0]       q4_q [NChan];
  // output
  logic              ov_q;
  logic [PixW-1:0]   opix_q, opix_d;

  logic [15:0]       eff_gain;
  logic [15:0]       gray_w [NChan];
  logic [25:0]       gray_sum;
  logic [ChanW-1:0]  gray;
  logic [ChanW-1:0]  c2_d [NChan];

  assign eff_gain  = (cfg_i.gain == '0) ? GAIN_UNITY : cfg_i.gain;
  assign gray_w[0] = GRAY_W0;
  assign gray_w[1] = GRAY_W1;
  assign gray_w[2] = GRAY_W2;

  always_comb begin
    for (int i = 0; i < NChan; i++) begin
      c2_d[i] = (gp1_q[i][23:16] != '0) ? 8'hFF : gp1_q[i][15:8];
    end
  end

  assign gray_sum = 26'(wp2_q[0]) + 26'(wp2_q[1]) + 26'(wp2_q[2]);
  assign gray     = gray_sum[23:16];

  always_comb begin
    priority if (r4_q.cls == CLS_KEY) begin
      opix_d = r4_q.backdrop;
    end else if (r4_q.cls == CLS_INVERT) begin
      opix_d = ~r4_q.sprite;
    end else begin
      for (int i = 0; i < NChan; i++) begin
        opix_d[i*ChanW +: ChanW] = q4_q[i][RECIP_SHIFT +: ChanW];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      ov_q <= 1'b0;
    end else begin
      v1_q <= req_valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
      ov_q <= v4_q;
    end
  end

  always_ff @(posedge clk_i) begin
    r1_q <= req_i;
    r2_q <= r1_q;
    r3_q <= r2_q;
    r4_q <= r3_q;
    for (int i = 0; i < NChan; i++) begin
      logic [ChanW-1:0] cc;
      cc = (cfg_i.effect_mode == EFF_GRAY) ? gray : c2_q[i];
      gp1_q[i]  <= 24'(req_i.sprite[i*ChanW +: ChanW]) * 24'(eff_gain);
      c2_q[i]   <= c2_d[i];
      wp2_q[i]  <= 24'(c2_d[i]) * 24'(gray_w[i]);
      sum3_q[i] <= 15'(cc) * 15'(cfg_i.opacity)
                 + 15'(r2_q.backdrop[i*ChanW +: ChanW]) * 15'(OPACITY_MAX - cfg_i.opacity);
      q4_q[i]   <= 31'(sum3_q[i]) * 31'(RECIP_100);
    end
    opix_q <= opix_d;
  end

  assign out_valid_o = ov_q;
  assign out_pixel_o = opix_q;

endmodule

>>> rtl/color_key_tint_alpha_blend.sv
// Top level of the color-key, tint and alpha-blend pixel compositor.
//
// Usage: drive start_i with a sprite pixel and the backdrop pixel beneath
// it; the request is taken at a rising edge where start_i is high and
// busy_o is low. Channel 0 sits in bits 7:0 of every pixel.
// One composited pixel comes back on out_pixel_o, marked by out_valid_o
// for exactly one cycle, in request order; the receiver cannot stall it.
// Each result passes the front register, queue slot, four datapath stages
// and output register before its strobe shows.
// Throughput: one pixel per clock, set by the fully pipelined datapath;
// the datapath never stalls, so the two-entry queue never fills and
// busy_o stays low in steady streaming.
// Configuration: write cfg_we_i/cfg_idx_i/cfg_wdata_i only while no
// request is in flight. Registers: 0 key color, 1 key tolerance (9-bit
// signed, negative never keys), 2 gain Q8.8, 3 opacity in percent
// (bits 6:0 above 100 hold 100), 4 effect mode (0 none, 1 invert, 2 gray).
// Reset: clears the pipeline and loads key 0, tolerance 0, gain 256,
// opacity 100 and no effect.
module color_key_tint_alpha_blend (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [23:0] cfg_wdata_i,
  input  logic        start_i,
  input  logic [23:0] sprite_pixel_i,
  input  logic [23:0] backdrop_pixel_i,
  output logic        busy_o,
  output logic        out_valid_o,
  output logic [23:0] out_pixel_o
);
  import ckb_pkg::*;

  ckb_cfg_t cfg_q, cfg_d;

  logic     front_valid, front_taken;
  ckb_req_t front_req;
  logic     q_valid, back_ready;
  ckb_req_t q_req;

  // Register writes; opacity bits 6:0 saturate at 100, unused indexes are dropped.
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_KEY_COLOR:     cfg_d.key_color     = cfg_wdata_i;
        REG_KEY_TOLERANCE: cfg_d.key_tolerance = cfg_wdata_i[8:0];
        REG_GAIN:          cfg_d.gain          = cfg_wdata_i[15:0];
        REG_OPACITY: begin
          cfg_d.opacity = (cfg_wdata_i[6:0] > OPACITY_MAX) ? OPACITY_MAX : cfg_wdata_i[6:0];
        end
        REG_EFFECT_MODE:   cfg_d.effect_mode   = cfg_wdata_i[1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.key_color     <= '0;
      cfg_q.key_tolerance <= '0;
      cfg_q.gain          <= GAIN_UNITY;
      cfg_q.opacity       <= OPACITY_MAX;
      cfg_q.effect_mode   <= EFF_NONE;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // Front end: take the request and classify it (keyed, inverted, blended).
  ckb_front u_front (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_i            (cfg_q),
    .start_i          (start_i),
    .sprite_pixel_i   (sprite_pixel_i),
    .backdrop_pixel_i (backdrop_pixel_i),
    .busy_o           (busy_o),
    .req_valid_o      (front_valid),
    .req_o            (front_req),
    .req_taken_i      (front_taken)
  );

  // Hold classified requests until the datapath takes them.
  ckb_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (front_valid),
    .push_req_i   (front_req),
    .push_taken_o (front_taken),
    .pop_valid_o  (q_valid),
    .pop_req_o    (q_req),
    .pop_ready_i  (back_ready)
  );

  // Datapath: advance one pixel per clock through gain, gray and blend.
  ckb_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .req_valid_i (q_valid),
    .req_i       (q_req),
    .req_ready_o (back_ready),
    .out_valid_o (out_valid_o),
    .out_pixel_o (out_pixel_o)
  );

endmodule

>>> test/color_key_tint_alpha_blend_tb.sv
// Self-checking testbench for the color-key, tint and alpha-blend compositor.
`timescale 1ns / 1ps

module color_key_tint_alpha_blend_tb;
  import ckb_pkg::*;

  localparam int unsigned CLK_HALF_NS   = 6;
  localparam int unsigned CYCLE_LIMIT   = 200000;
  localparam int unsigned SETTLE_CYCLES = 10;    // covers the whole pipeline
  localparam int unsigned MAX_GAP       = 14;
  localparam int unsigned RANDOM_PHASES = 8;
  localparam logic [CfgIdxW-1:0] FIRST_UNUSED_IDX = 3'd5;
  localparam logic [CfgIdxW-1:0] LAST_UNUSED_IDX  = 3'd7;

  // Scoreboard: mirrors the register file, predicts each composited pixel
  // at the accepting edge and checks results in request order.
  class blend_scoreboard;
    logic [PixW-1:0]  key_color;
    int               key_tol;
    logic [15:0]      gain;
    int unsigned      opacity;
    logic [1:0]       effect;
    logic [PixW-1:0]  pending_pixels[$];
    int unsigned      errors;

    function new();
      key_color = '0;
      key_tol   = 0;
      gain      = GAIN_UNITY;
      opacity   = OPACITY_MAX;
      effect    = EFF_NONE;
      errors    = 0;
    endfunction

    function void write_reg(logic [CfgIdxW-1:0] idx, logic [23:0] data);
      case (idx)
        REG_KEY_COLOR:     key_color = data[PixW-1:0];
        REG_KEY_TOLERANCE: key_tol   = int'($signed(data[8:0]));
        REG_GAIN:          gain      = data[15:0];
        REG_OPACITY: begin
          opacity = (data[6:0] > OPACITY_MAX) ? OPACITY_MAX : data[6:0];
        end
        REG_EFFECT_MODE:   effect    = data[1:0];
        default: ;
      endcase
    endfunction

    function logic [PixW-1:0] predict_pixel(logic [PixW-1:0] spr, logic [PixW-1:0] bg);
      int unsigned     ch[NChan];
      int unsigned     sc, bc, kc, v, gray;
      int              delta;
      bit              keyed;
      logic [PixW-1:0] res;
      keyed = 1'b1;
      res   = '0;
      for (int i = 0; i < NChan; i++) begin
        sc    = spr[i*ChanW +: ChanW];
        kc    = key_color[i*ChanW +: ChanW];
        delta = int'(sc) - int'(kc);
        if (delta < 0) delta = -delta;
        if (delta > key_tol) keyed = 1'b0;
      end
      if (keyed) return bg;
      if (effect == EFF_INVERT) return ~spr;
      // Scale by gain; zero and unity leave the channel alone
      for (int i = 0; i < NChan; i++) begin
        sc = spr[i*ChanW +: ChanW];
        if (gain == 16'd0 || gain == GAIN_UNITY) begin
          ch[i] = sc;
        end else begin
          v     = (sc * gain) >> 8;
          ch[i] = (v > 255) ? 255 : v;
        end
      end
      if (effect == EFF_GRAY) begin
        gray = (ch[0] * GRAY_W0 + ch[1] * GRAY_W1 + ch[2] * GRAY_W2) >> 16;
        for (int i = 0; i < NChan; i++) ch[i] = gray;
      end
      for (int i = 0; i < NChan; i++) begin
        bc = bg[i*ChanW +: ChanW];
        v  = (ch[i] * opacity + bc * (OPACITY_MAX - opacity)) / OPACITY_MAX;
        res[i*ChanW +: ChanW] = v[ChanW-1:0];
      end
      return res;
    endfunction

    function void note_request(logic [PixW-1:0] spr, logic [PixW-1:0] bg);
      pending_pixels.push_back(predict_pixel(spr, bg));
    endfunction

    function void check_pixel(logic [PixW-1:0] actual);
      logic [PixW-1:0] exp_pix;
      if (pending_pixels.size() == 0) begin
        $error("out_pixel: no request pending, got %06h", actual);
        errors++;
        return;
      end
      exp_pix = pending_pixels.pop_front();
      if (actual !== exp_pix) begin
        $error("out_pixel: expected %06h, actual %06h", exp_pix, actual);
        errors++;
      end
    endfunction
  endclass

  logic              clk_i;
  logic              rst_ni;
  logic              cfg_we_i;
  logic [2:0]        cfg_idx_i;
  logic [23:0]       cfg_wdata_i;
  logic              start_i;
  logic [PixW-1:0]   sprite_pixel_i;
  logic [PixW-1:0]   backdrop_pixel_i;
  logic              busy_o;
  logic              out_valid_o;
  logic [PixW-1:0]   out_pixel_o;

  blend_scoreboard   board;
  int unsigned       cycle_count;

  color_key_tint_alpha_blend u_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_idx_i        (cfg_idx_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .start_i          (start_i),
    .sprite_pixel_i   (sprite_pixel_i),
    .backdrop_pixel_i (backdrop_pixel_i),
    .busy_o           (busy_o),
    .out_valid_o      (out_valid_o),
    .out_pixel_o      (out_pixel_o)
  );

  always begin
    clk_i = 1'b1;
    #(CLK_HALF_NS);
    clk_i = 1'b0;
    #(CLK_HALF_NS);
  end

  // Watchdog: end the run if the pipeline hangs or a drain never finishes
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // Sample the strobe mid-cycle, where outputs are settled; the receiver
  // cannot stall, so every strobe is a delivered result.
  always @(negedge clk_i) begin
    if (rst_ni && out_valid_o === 1'b1) board.check_pixel(out_pixel_o);
  end

  // Write one register; the caller lowers cfg_we_i after the last write so
  // back-to-back writes keep the enable high without a glitch.
  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [23:0] data);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    board.write_reg(idx, data);
  endtask

  // Program all five registers, occasionally poke an unmapped index too.
  task automatic program_setting(input logic [23:0] key_w, input logic [23:0] tol_w,
                                 input logic [23:0] gain_w, input logic [23:0] op_w,
                                 input logic [23:0] eff_w);
    write_reg(REG_KEY_COLOR, key_w);
    write_reg(REG_KEY_TOLERANCE, tol_w);
    write_reg(REG_GAIN, gain_w);
    write_reg(REG_OPACITY, op_w);
    write_reg(REG_EFFECT_MODE, eff_w);
    if ($urandom_range(0, 2) == 0) begin
      write_reg(3'($urandom_range(FIRST_UNUSED_IDX, LAST_UNUSED_IDX)), 24'($urandom()));
    end
    cfg_we_i <= 1'b0;
  endtask

  // Issue one request after an idle gap; hold it until an edge with busy low.
  task automatic send_pixel(input logic [PixW-1:0] spr, input logic [PixW-1:0] bg,
                            input int unsigned gap);
    bit taken;
    if (gap > 0) begin
      start_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start_i          <= 1'b1;
    sprite_pixel_i   <= spr;
    backdrop_pixel_i <= bg;
    do begin
      @(negedge clk_i);
      taken = (busy_o === 1'b0);
      @(posedge clk_i);
    end while (!taken);
    board.note_request(spr, bg);
  endtask

  // Drop start, wait for every pending pixel, then let the pipeline settle.
  task automatic drain_pipeline();
    start_i <= 1'b0;
    while (board.pending_pixels.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Channel close to the key, so the per-channel tolerance edge is hit often
  function automatic logic [7:0] near_chan(logic [7:0] k, int tol);
    int spread, v;
    spread = (tol < 0) ? 2 : ((tol > 30) ? 32 : tol + 2);
    v = int'(k) + int'($urandom_range(0, 2 * spread)) - spread;
    if (v < 0) v = 0;
    if (v > 255) v = 255;
    return v[7:0];
  endfunction

  // Junk above the register width in about a quarter of the writes
  function automatic logic [23:0] with_junk(logic [23:0] val, int unsigned width);
    logic [23:0] junk;
    junk = 24'($urandom());
    if ($urandom_range(0, 3) != 0 || width >= 24) return val;
    return (junk & ~((24'd1 << width) - 24'd1)) | val;
  endfunction

  task automatic random_setting();
    logic [23:0] key_w, tol_w, gain_w, op_w, eff_w;
    key_w = 24'($urandom());
    case ($urandom_range(0, 4))
      0:       tol_w = 24'h1ff;                      // never keys
      1:       tol_w = 24'd0;
      2:       tol_w = 24'd255;                      // keys everything
      3:       tol_w = 24'($urandom_range(1, 40));
      default: tol_w = 24'($urandom_range(0, 511));
    endcase
    case ($urandom_range(0, 4))
      0:       gain_w = 24'd0;
      1:       gain_w = 24'(GAIN_UNITY);
      2:       gain_w = 24'hffff;
      3:       gain_w = 24'($urandom_range(0, 600));
      default: gain_w = 24'($urandom_range(0, 65535));
    endcase
    case ($urandom_range(0, 3))
      0:       op_w = 24'd0;
      1:       op_w = 24'(OPACITY_MAX);
      2:       op_w = 24'd127;                       // saturates to full
      default: op_w = 24'($urandom_range(0, 127));
    endcase
    eff_w = 24'($urandom_range(0, 3));
    program_setting(key_w, with_junk(tol_w, 9), with_junk(gain_w, 16),
                    with_junk(op_w, 7), with_junk(eff_w, 2));
  endtask

  task automatic random_phase(input int unsigned n_items);
    bit              no_idle;
    logic [PixW-1:0] spr, bg;
    int unsigned     pick;
    no_idle = ($urandom_range(0, 9) < 3);
    for (int unsigned n = 0; n < n_items; n++) begin
      pick = $urandom_range(0, 9);
      bg   = PixW'($urandom());
      if (pick == 0) begin
        spr = board.key_color;
      end else if (pick < 5) begin
        for (int i = 0; i < NChan; i++) begin
          spr[i*ChanW +: ChanW] = near_chan(board.key_color[i*ChanW +: ChanW], board.key_tol);
        end
      end else begin
        spr = PixW'($urandom());
      end
      send_pixel(spr, bg, no_idle ? 0 : $urandom_range(0, MAX_GAP));
    end
    drain_pipeline();
  endtask

  initial begin
    board            = new();
    cycle_count      = 0;
    rst_ni           = 1'b0;
    cfg_we_i         = 1'b0;
    cfg_idx_i        = '0;
    cfg_wdata_i      = '0;
    start_i          = 1'b0;
    sprite_pixel_i   = '0;
    backdrop_pixel_i = '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset values: key 0 with zero tolerance keys only pure black
    send_pixel(24'h000000, 24'h123456, 0);
    send_pixel(24'h000001, 24'habcdef, 0);
    send_pixel(24'hffffff, 24'h000000, 1);
    send_pixel(24'h800000, 24'hffffff, 0);
    drain_pipeline();

    // Full tolerance: every sprite pixel is transparent
    program_setting(24'h1080f0, 24'd255, 24'd0, 24'(OPACITY_MAX), 24'(EFF_NONE));
    send_pixel(24'hffffff, 24'h5a5a5a, 0);
    send_pixel(24'h000000, 24'ha5a5a5, 2);
    drain_pipeline();

    // Negative tolerance never keys, top gain saturates every nonzero channel
    program_setting(24'h000000, 24'h1ff, 24'hffff, 24'(OPACITY_MAX), 24'(EFF_NONE));
    send_pixel(24'h000000, 24'h111111, 0);
    send_pixel(24'h010203, 24'hfedcba, 0);
    send_pixel(24'hff80ff, 24'h000000, 0);
    drain_pipeline();

    // Invert: inside tolerance keys, one step outside inverts the raw sprite
    program_setting(24'h404040, 24'd3, 24'd512, 24'd0, 24'(EFF_INVERT));
    send_pixel(24'h424140, 24'h0f0f0f, 0);
    send_pixel(24'h444040, 24'h0f0f0f, 0);
    send_pixel(24'h000000, 24'h777777, 3);
    drain_pipeline();

    // Grayscale after gain; an opacity write above the range holds full
    program_setting(24'h000000, 24'h1ff, 24'd384, 24'd127, 24'(EFF_GRAY));
    send_pixel(24'hffffff, 24'h000000, 0);
    send_pixel(24'h102030, 24'hffffff, 0);
    send_pixel(24'hff0000, 24'h00ff00, 0);
    drain_pipeline();

    // Zero opacity passes the backdrop; the unused effect code blends plainly
    program_setting(24'hffffff, 24'h1ff, 24'd255, 24'd0, 24'd3);
    send_pixel(24'hffffff, 24'h123456, 0);
    send_pixel(24'habcdef, 24'h00ff00, 0);
    drain_pipeline();

    // Half opacity with doubled gain, junk in the upper write bits
    program_setting(24'hffffff, 24'hfffe00, 24'hff0200, 24'hffff32, 24'hfffffc);
    send_pixel(24'hffffff, 24'h000000, 0);
    send_pixel(24'h7f7f7f, 24'h010101, 0);
    send_pixel(24'h808080, 24'hffffff, 0);
    drain_pipeline();

    // Random settings, each followed by a stream of pixels, half of them on or near the key
    for (int unsigned p = 0; p < RANDOM_PHASES; p++) begin
      random_setting();
      random_phase($urandom_range(70, 105));
    end

    if (board.errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

>>> files.f
rtl/ckb_pkg.sv
rtl/ckb_front.sv
rtl/ckb_queue.sv
rtl/ckb_back.sv
rtl/color_key_tint_alpha_blend.sv
test/color_key_tint_alpha_blend_tb.sv
